@@ sv/clws_pkg.sv @@
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types, command codes and the init byte table for the character LCD
// write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clws_pkg;

  localparam int unsigned CursorW = 7;
  localparam int unsigned StepW   = 3;

  // Request codes; 6 and 7 write nothing and give one empty beat.
  typedef enum logic [2:0] {
    REQ_INIT      = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_PUT_CHAR  = 3'd2,
    REQ_GOTO_RC   = 3'd3,
    REQ_GOTO_ADDR = 3'd4,
    REQ_GLYPH_ROW = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COORD = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  // Command bytes
  localparam logic [7:0] CMD_FUNC_8BIT   = 8'h30;
  localparam logic [7:0] CMD_FUNC_2LINE  = 8'h38;
  localparam logic [7:0] CMD_DISP_ON     = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h04;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [1:0] CMD_CGRAM_TOP   = 2'b01;   // 0x40 with a 6-bit address
  localparam logic       CMD_DDRAM_TOP   = 1'b1;    // 0x80 with a 7-bit address

  localparam logic [CursorW-1:0] PAST_END = 7'd96;

  // Steps of one request's output sequence
  localparam logic [StepW-1:0] STEP_FIRST = 3'd0;
  localparam logic [StepW-1:0] STEP_DATA  = 3'd1;
  localparam logic [StepW-1:0] STEP_INIT_LAST = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         char_byte;
    logic [2:0]         row;
    logic [4:0]         column;
    logic [6:0]         address;
  } req_t;

  typedef struct packed {
    logic               bus_write;
    logic               reg_select;
    logic [7:0]         bus_byte;
    status_e            status;
    logic [CursorW-1:0] cursor_addr;
    logic               last;
  } res_t;

  // Decoded request, held while its beats go out
  typedef struct packed {
    logic               init_seq;
    logic               wr;
    logic               two_beats;
    logic [7:0]         cmd_byte;
    logic [7:0]         data_byte;
    status_e            status;
    logic [CursorW-1:0] cursor;
  } plan_t;

  function automatic logic [7:0] init_byte(input logic [StepW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CMD_FUNC_8BIT;
      3'd1:    b = CMD_FUNC_2LINE;
      3'd2:    b = CMD_DISP_ON;
      3'd3:    b = CMD_ENTRY_MODE;
      3'd4:    b = CMD_CLEAR;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/clws_decode.sv @@
// ----------------------------------------------------------------------------
// clws_decode
// Turns one request and the current cursor into a bus-write plan and the
// cursor that follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_decode (
  input  clws_pkg::req_t                     req_i,
  input  logic [clws_pkg::CursorW-1:0]       cursor_i,
  output clws_pkg::plan_t                    plan_o,
  output logic [clws_pkg::CursorW-1:0]       cursor_nxt_o
);
  import clws_pkg::*;

  localparam logic [CursorW:0] ROW0_END = 8'd16;
  localparam logic [CursorW:0] ROW1_END = 8'd80;
  localparam logic [CursorW:0] ROW2_END = 8'd32;
  localparam logic [CursorW-1:0] ROW1_START = 7'd64;
  localparam logic [CursorW-1:0] ROW2_START = 7'd16;
  localparam logic [CursorW-1:0] ROW3_START = 7'd80;

  // Step to the next cell in display row order 0, 1, 2, 3
  function automatic logic [CursorW-1:0] advance(input logic [CursorW-1:0] a);
    logic [CursorW:0] n;
    logic [CursorW-1:0] r;
    n = {1'b0, a} + 8'd1;
    priority if (n == ROW0_END) begin
      r = ROW1_START;
    end else if (n == ROW1_END) begin
      r = ROW2_START;
    end else if (n == ROW2_END) begin
      r = ROW3_START;
    end else if (n > {1'b0, PAST_END}) begin
      r = PAST_END;
    end else begin
      r = n[CursorW-1:0];
    end
    return r;
  endfunction

  logic [CursorW-1:0] rc_addr;

  // Row bases 0, 64, 16, 80 have clear low nibbles: splice the column in
  assign rc_addr = {req_i.row[0], 1'b0, req_i.row[1], req_i.column[3:0]};

  always_comb begin
    plan_o           = '0;
    plan_o.status    = ST_OK;
    cursor_nxt_o     = cursor_i;
    unique case (req_i.req_type)
      REQ_INIT: begin
        plan_o.init_seq = 1'b1;
        plan_o.wr       = 1'b1;
        cursor_nxt_o    = '0;
      end
      REQ_CLEAR: begin
        plan_o.wr       = 1'b1;
        plan_o.cmd_byte = CMD_CLEAR;
        cursor_nxt_o    = '0;
      end
      REQ_PUT_CHAR: begin
        if (cursor_i >= PAST_END) begin
          plan_o.status = ST_FULL;
        end else begin
          plan_o.wr        = 1'b1;
          plan_o.two_beats = 1'b1;
          plan_o.cmd_byte  = {CMD_DDRAM_TOP, cursor_i};
          plan_o.data_byte = req_i.char_byte;
          cursor_nxt_o     = advance(cursor_i);
        end
      end
      REQ_GOTO_RC: begin
        if (!req_i.row[2] && !req_i.column[4]) begin
          plan_o.wr       = 1'b1;
          plan_o.cmd_byte = {CMD_DDRAM_TOP, rc_addr};
          cursor_nxt_o    = rc_addr;
        end else begin
          plan_o.status = ST_BAD_COORD;
        end
      end
      REQ_GOTO_ADDR: begin
        // Valid windows 0x00-0x1F and 0x40-0x5F share a clear bit 5
        if (!req_i.address[5]) begin
          plan_o.wr       = 1'b1;
          plan_o.cmd_byte = {CMD_DDRAM_TOP, req_i.address};
          cursor_nxt_o    = req_i.address;
        end else begin
          plan_o.status = ST_BAD_ADDR;
        end
      end
      REQ_GLYPH_ROW: begin
        if (!req_i.address[6]) begin
          plan_o.wr        = 1'b1;
          plan_o.two_beats = 1'b1;
          plan_o.cmd_byte  = {CMD_CGRAM_TOP, req_i.address[5:0]};
          plan_o.data_byte = req_i.char_byte;
        end else begin
          plan_o.status = ST_BAD_ADDR;
        end
      end
      default: begin
        // unused request: one empty beat
      end
    endcase
    plan_o.cursor = cursor_nxt_o;
  end

endmodule

`default_nettype wire

@@ sv/clws_emit.sv @@
// ----------------------------------------------------------------------------
// clws_emit
// Holds one decoded plan and sends its beats, one per cycle while the
// receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clws_pkg::plan_t  plan_i,
  input  logic             plan_valid_i,
  output logic             plan_ready_o,
  output clws_pkg::res_t   res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);
  import clws_pkg::*;

  plan_t             plan_q;
  logic              plan_vld_q;
  logic [StepW-1:0]  step_q;
  logic [StepW-1:0]  last_step;
  logic              is_last;
  logic              load;
  logic              take;
  res_t              res_d;
  res_t              res_q;
  logic              res_vld_q;

  assign last_step = plan_q.init_seq  ? STEP_INIT_LAST :
                     plan_q.two_beats ? STEP_DATA : STEP_FIRST;
  assign is_last   = (step_q == last_step);
  assign load      = plan_vld_q && (!res_vld_q || res_ready_i);
  assign plan_ready_o = !plan_vld_q || (load && is_last);
  assign take      = plan_valid_i && plan_ready_o;

  always_comb begin
    res_d             = '0;
    res_d.bus_write   = plan_q.wr;
    res_d.reg_select  = plan_q.two_beats && (step_q == STEP_DATA);
    if (plan_q.init_seq) begin
      res_d.bus_byte = init_byte(step_q);
    end else if (step_q == STEP_DATA) begin
      res_d.bus_byte = plan_q.data_byte;
    end else begin
      res_d.bus_byte = plan_q.cmd_byte;
    end
    res_d.status      = plan_q.status;
    res_d.cursor_addr = plan_q.cursor;
    res_d.last        = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_vld_q <= 1'b0;
      step_q     <= STEP_FIRST;
      res_vld_q  <= 1'b0;
    end else begin
      if (take) begin
        plan_vld_q <= 1'b1;
        step_q     <= STEP_FIRST;
      end else if (load && is_last) begin
        plan_vld_q <= 1'b0;
      end else if (load) begin
        step_q <= StepW'(step_q + 3'd1);
      end
      if (load) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      plan_q <= plan_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

endmodule

`default_nettype wire

@@ sv/char_lcd_write_sequencer_top.sv @@
// Path: a request is taken into the plan register, and its beats then go out
// through the single output register that the plan register feeds.
// Throughput: one output beat per cycle while the receiver is ready.
// Beats: put character and glyph row 2, init 5, all others and refusals 1.
// Reset: asynchronous, active low; clears the cursor to 0 and empties both
// the plan and output registers.
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Character LCD write sequencer: requests in, register-select/byte beats out.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  clws_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output clws_pkg::res_t  out_data_o
);
  import clws_pkg::*;

  logic [CursorW-1:0] cursor_q;
  logic [CursorW-1:0] cursor_d;
  plan_t              plan;
  logic               in_take;

  assign in_take = in_valid_i && in_ready_o;

  clws_decode u_decode (
    .req_i        (in_data_i),
    .cursor_i     (cursor_q),
    .plan_o       (plan),
    .cursor_nxt_o (cursor_d)
  );

  // Cursor moves as soon as the request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (in_take) begin
      cursor_q <= cursor_d;
    end
  end

  clws_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_i       (plan),
    .plan_valid_i (in_valid_i),
    .plan_ready_o (in_ready_o),
    .res_o        (out_data_o),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i)
  );

endmodule

`default_nettype wire

@@ sv/clws_checker.sv @@
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks on the output beats of the LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            out_valid_o,
  input  logic            out_ready_i,
  input  clws_pkg::res_t  out_data_o
);
  import clws_pkg::*;

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A beat without a bus write carries no byte
  a_idle_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bus_write |->
      !out_data_o.reg_select && (out_data_o.bus_byte == 8'h00))
    else $error("non-write beat carries bus data");

  // The data byte is always the final beat of its request
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reg_select |->
      out_data_o.last && out_data_o.bus_write)
    else $error("data beat not final");

  // A refused request gives one empty beat
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      out_data_o.last && !out_data_o.bus_write)
    else $error("error status on a bus write or non-final beat");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cursor_addr <= PAST_END)
    else $error("cursor beyond past-end mark");

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ test/char_lcd_write_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD write sequencer testbench
// Sends LCD requests to the sequencer and predicts the bus beats that each
// one should cause, cursor included. Every output beat is checked in order
// against that prediction. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------

module testbench;
  import clws_pkg::*;

  // Spare request codes that the block ignores
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam logic [7:0] INIT_SEQ [0:4] = '{CMD_FUNC_8BIT, CMD_FUNC_2LINE, CMD_DISP_ON,
                                            CMD_ENTRY_MODE, CMD_CLEAR};
  localparam logic [6:0] ROW_BASE [0:3] = '{7'd0, 7'd64, 7'd16, 7'd80};

  localparam int RANDOM_ITEMS = 480;

  class lcd_bus_tracker;
    res_t       beats_due[$];
    logic [6:0] cursor;
    int         errors;
    int         n_requests;
    int         n_beats;
    int         n_full;
    int         n_bad_coord;
    int         n_bad_addr;

    function new();
      cursor = '0;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function res_t make_beat(logic wr, logic rs, logic [7:0] data, status_e st);
      res_t b;
      b = '0;
      b.bus_write  = wr;
      b.reg_select = rs;
      b.bus_byte   = data;
      b.status     = st;
      return b;
    endfunction

    // Display order: row 0, row 1, row 2, row 3, then park past the end
    function logic [6:0] next_cell(logic [6:0] a);
      logic [7:0] n;
      n = {1'b0, a} + 8'd1;
      case (n)
        8'd16:   n = 8'd64;
        8'd80:   n = 8'd16;
        8'd32:   n = 8'd80;
        default: if (n > {1'b0, PAST_END}) n = {1'b0, PAST_END};
      endcase
      return n[6:0];
    endfunction

    function void note_request(req_t r);
      res_t       seq[$];
      logic [6:0] a;
      n_requests++;
      case (r.req_type)
        REQ_INIT: begin
          foreach (INIT_SEQ[i]) seq.push_back(make_beat(1'b1, 1'b0, INIT_SEQ[i], ST_OK));
          cursor = '0;
        end
        REQ_CLEAR: begin
          seq.push_back(make_beat(1'b1, 1'b0, CMD_CLEAR, ST_OK));
          cursor = '0;
        end
        REQ_PUT_CHAR: begin
          if (cursor >= PAST_END) begin
            seq.push_back(make_beat(1'b0, 1'b0, 8'h00, ST_FULL));
            n_full++;
          end else begin
            seq.push_back(make_beat(1'b1, 1'b0, {CMD_DDRAM_TOP, cursor}, ST_OK));
            seq.push_back(make_beat(1'b1, 1'b1, r.char_byte, ST_OK));
            cursor = next_cell(cursor);
          end
        end
        REQ_GOTO_RC: begin
          if (r.row < 3'd4 && r.column < 5'd16) begin
            a = ROW_BASE[r.row[1:0]] + {2'b00, r.column};
            seq.push_back(make_beat(1'b1, 1'b0, {CMD_DDRAM_TOP, a}, ST_OK));
            cursor = a;
          end else begin
            seq.push_back(make_beat(1'b0, 1'b0, 8'h00, ST_BAD_COORD));
            n_bad_coord++;
          end
        end
        REQ_GOTO_ADDR: begin
          if (r.address <= 7'h1F || (r.address >= 7'h40 && r.address <= 7'h5F)) begin
            seq.push_back(make_beat(1'b1, 1'b0, {CMD_DDRAM_TOP, r.address}, ST_OK));
            cursor = r.address;
          end else begin
            seq.push_back(make_beat(1'b0, 1'b0, 8'h00, ST_BAD_ADDR));
            n_bad_addr++;
          end
        end
        REQ_GLYPH_ROW: begin
          if (r.address < 7'd64) begin
            seq.push_back(make_beat(1'b1, 1'b0, {CMD_CGRAM_TOP, r.address[5:0]}, ST_OK));
            seq.push_back(make_beat(1'b1, 1'b1, r.char_byte, ST_OK));
          end else begin
            seq.push_back(make_beat(1'b0, 1'b0, 8'h00, ST_BAD_ADDR));
            n_bad_addr++;
          end
        end
        default: seq.push_back(make_beat(1'b0, 1'b0, 8'h00, ST_OK));
      endcase
      foreach (seq[i]) begin
        seq[i].cursor_addr = cursor;
        seq[i].last        = (i == seq.size() - 1);
        beats_due.push_back(seq[i]);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(res_t got);
      res_t want;
      n_beats++;
      if (beats_due.size() == 0) begin
        $error("beat with nothing expected: 0x%0h", got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      check_field("bus_write", 32'(want.bus_write), 32'(got.bus_write));
      check_field("reg_select", 32'(want.reg_select), 32'(got.reg_select));
      check_field("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("cursor_addr", 32'(want.cursor_addr), 32'(got.cursor_addr));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_data_o;

  lcd_bus_tracker bus_model = new();
  int burst_left = 0;
  int rx_cycle   = 0;

  char_lcd_write_sequencer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver: cycle through always ready, coin toss, mostly stalled, fixed rhythm
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 150) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((rx_cycle % 8) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) bus_model.check_beat(out_data_o);
  end

  function automatic req_t mk_req(logic [2:0] kind, logic [7:0] ch, logic [2:0] row,
                                  logic [4:0] col, logic [6:0] addr);
    req_t r;
    r.req_type  = kind;
    r.char_byte = ch;
    r.row       = row;
    r.column    = col;
    r.address   = addr;
    return r;
  endfunction

  function automatic req_t noise_req();
    return mk_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                  7'($urandom_range(0, 127)));
  endfunction

  // Bursts of back-to-back requests with random gaps in between
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    bus_model.note_request(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (bus_model.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_request(mk_req(REQ_INIT, 8'h00, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_PUT_CHAR, 8'h00, 3'd7, 5'd31, 7'd127));
    send_request(mk_req(REQ_PUT_CHAR, 8'hFF, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_CLEAR, 8'hFF, 3'd7, 5'd31, 7'd127));
    send_request(mk_req(REQ_GOTO_RC, 8'h00, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_GOTO_RC, 8'h00, 3'd3, 5'd15, 7'd0));
    send_request(mk_req(REQ_GOTO_RC, 8'h00, 3'd4, 5'd0, 7'd0));
    send_request(mk_req(REQ_GOTO_RC, 8'h00, 3'd7, 5'd31, 7'd0));
    send_request(mk_req(REQ_GOTO_RC, 8'h00, 3'd1, 5'd16, 7'd0));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h1F));
    send_request(mk_req(REQ_PUT_CHAR, 8'h41, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h20));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h3F));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h60));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h7F));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h40));
    send_request(mk_req(REQ_GOTO_ADDR, 8'h00, 3'd0, 5'd0, 7'h5F));
    // last cell, then the display is full
    send_request(mk_req(REQ_PUT_CHAR, 8'h5A, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_PUT_CHAR, 8'h5B, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_GLYPH_ROW, 8'h00, 3'd0, 5'd0, 7'd0));
    send_request(mk_req(REQ_GLYPH_ROW, 8'hFF, 3'd0, 5'd0, 7'd63));
    send_request(mk_req(REQ_GLYPH_ROW, 8'h1F, 3'd0, 5'd0, 7'd64));
    send_request(mk_req(REQ_GLYPH_ROW, 8'h1F, 3'd0, 5'd0, 7'd127));
    send_request(mk_req(REQ_SPARE_6, 8'hFF, 3'd7, 5'd31, 7'd127));
    send_request(mk_req(REQ_SPARE_7, 8'h00, 3'd0, 5'd0, 7'd0));
  endtask

  task automatic run_random();
    int   sent;
    int   len;
    int   pick;
    bit   held;
    req_t r;
    sent = 0;
    held = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!held && sent >= RANDOM_ITEMS / 2) begin
        wait_idle();
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // position the cursor, often near a row end, then write a run
        if ($urandom_range(0, 1))
          r = mk_req(REQ_GOTO_RC, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 3)),
                     5'($urandom_range(0, 1) ? $urandom_range(10, 15)
                                              : $urandom_range(0, 15)),
                     7'($urandom_range(0, 127)));
        else
          r = mk_req(REQ_GOTO_ADDR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                     5'($urandom_range(0, 31)),
                     {$urandom_range(0, 1) ? 2'b10 : 2'b00, 5'($urandom_range(0, 31))});
        send_request(r);
        sent++;
        len = $urandom_range(1, 20);
        repeat (len) begin
          send_request(mk_req(REQ_PUT_CHAR, 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                              7'($urandom_range(0, 127))));
          sent++;
        end
      end else if (pick < 45) begin
        // fill the whole display and run past the end
        send_request(mk_req($urandom_range(0, 1) ? REQ_INIT : REQ_CLEAR,
                            8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                            5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
        sent++;
        len = $urandom_range(64, 70);
        repeat (len) begin
          send_request(mk_req(REQ_PUT_CHAR, 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                              7'($urandom_range(0, 127))));
          sent++;
        end
      end else if (pick < 60) begin
        // one glyph, row by row
        len  = $urandom_range(1, 8);
        pick = $urandom_range(0, 7) * 8;
        for (int i = 0; i < len; i++) begin
          send_request(mk_req(REQ_GLYPH_ROW, 8'($urandom_range(0, 31)),
                              3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                              7'(pick + i)));
          sent++;
        end
      end else begin
        r = noise_req();
        send_request(r);
        if (r.req_type <= REQ_GLYPH_ROW) sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_idle();
    run_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (bus_model.pending() != 0) begin
      $error("%0d beats never arrived", bus_model.pending());
      bus_model.errors++;
    end
    $display("Covered %0d requests and %0d bus beats.", bus_model.n_requests,
             bus_model.n_beats);
    $display("Dropped characters %0d, bad coordinates %0d, bad addresses %0d.",
             bus_model.n_full, bus_model.n_bad_coord, bus_model.n_bad_addr);
    if (bus_model.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d beats outstanding", bus_model.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
